@@ rtl/tetrahedron_circumsphere_unit_defines.svh @@
// Assertion macros for the checker file.
`ifndef TETRAHEDRON_CIRCUMSPHERE_UNIT_DEFINES_SVH
`define TETRAHEDRON_CIRCUMSPHERE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/tcs_pkg.sv @@
`timescale 1ns / 1ps

package tcs_pkg;
	localparam int COORD_W = 16;
	localparam int E_W = 17;
	localparam int SQ_W = 34;
	localparam int CR_W = 34;
	localparam int DET_W = 54;
	localparam int T_W = 69;
	localparam int N_W = 72;
	localparam int PD_W = 70;
	localparam int TOT_W = 80;
	localparam int RES_W = 32;
	localparam int CQ_W = 32;
	localparam int RQ_W = 33;
	localparam int HALF_W = 35;
	localparam int NA_W = 2 * HALF_W;
	localparam int SQR_W = 140;
	localparam int X_SHIFT = 16;
	localparam int ROOT_W = 78;
	localparam int X_W = 2 * ROOT_W;
	localparam int COORD_FRAC = 8;
	localparam int N_SCALE = 7;

	localparam int FRONT_LAT = 3;
	localparam int LANE_PRE = 5;
	localparam int LANE_LAT = LANE_PRE + CQ_W + 2;
	localparam int RAD_TAP = 2;
	localparam int RAD_PRE = 4;
	localparam int RAD_LAT = RAD_PRE + ROOT_W + RQ_W + 2;
	localparam int CDELAY = RAD_TAP + RAD_LAT - LANE_LAT;
	localparam int PIPE_LAT = FRONT_LAT + RAD_TAP + RAD_LAT + 1;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic [RES_W-1:0] center;
		logic             bad;
	} lane_res_t;

	typedef struct packed {
		logic [RES_W-1:0] radius;
		logic             bad;
	} rad_res_t;
endpackage

@@ rtl/tetrahedron_circumsphere_unit.sv @@
`timescale 1ns / 1ps

// Circumsphere of a tetrahedron given its four corners in signed Q8.8. Each
// request returns the center in signed Q16.16 (rounded to nearest, ties away
// from zero) and the radius in unsigned Q16.16 (ties up), exact in between.
// The unit takes one request per clock while in_stall is low. The radius
// path, a 78-step square root pipeline followed by a 34-stage divider, is
// the longest of all paths in the unit. Three center lanes, one per axis,
// each run a 33-stage divider and are aligned to the radius path before the
// merge stage. Coplanar corners, or a center or radius out of range, give
// degenerate = 1 with all other outputs zero. out_stall holds the whole
// pipeline only while a finished result is waiting at the output.
module tetrahedron_circumsphere_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [tcs_pkg::COORD_W-1:0] a_x,
	input  logic signed [tcs_pkg::COORD_W-1:0] a_y,
	input  logic signed [tcs_pkg::COORD_W-1:0] a_z,
	input  logic signed [tcs_pkg::COORD_W-1:0] b_x,
	input  logic signed [tcs_pkg::COORD_W-1:0] b_y,
	input  logic signed [tcs_pkg::COORD_W-1:0] b_z,
	input  logic signed [tcs_pkg::COORD_W-1:0] c_x,
	input  logic signed [tcs_pkg::COORD_W-1:0] c_y,
	input  logic signed [tcs_pkg::COORD_W-1:0] c_z,
	input  logic signed [tcs_pkg::COORD_W-1:0] d_x,
	input  logic signed [tcs_pkg::COORD_W-1:0] d_y,
	input  logic signed [tcs_pkg::COORD_W-1:0] d_z,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [tcs_pkg::RES_W-1:0]   center_x,
	output logic signed [tcs_pkg::RES_W-1:0]   center_y,
	output logic signed [tcs_pkg::RES_W-1:0]   center_z,
	output logic [tcs_pkg::RES_W-1:0]          sphere_radius,
	output logic                              degenerate
);
	localparam int PIPE_LAT = tcs_pkg::PIPE_LAT;
	localparam int CDELAY = tcs_pkg::CDELAY;
	localparam int RES_W = tcs_pkg::RES_W;

	logic                                en;
	logic [PIPE_LAT-1:0]                 vld_q;
	tcs_pkg::coord_t                     pt  [4][3];
	tcs_pkg::coord_t                     p0  [3];
	logic [tcs_pkg::SQ_W-1:0]            sq  [3];
	logic signed [tcs_pkg::CR_W-1:0]     cr  [3][3];
	logic signed [tcs_pkg::DET_W-1:0]    det;
	logic signed [tcs_pkg::N_W-1:0]      n_all [3];
	logic signed [tcs_pkg::DET_W-1:0]    det_tap;
	tcs_pkg::lane_res_t                  lane_res [3];
	tcs_pkg::lane_res_t                  cd_q [3][CDELAY];
	tcs_pkg::rad_res_t                   rad_res;
	logic                                bad;
	logic [RES_W-1:0]                    cx_q, cy_q, cz_q, rad_q;
	logic                                degen_q;

	// advance unless a finished result is held at the output
	assign en       = ~(vld_q[PIPE_LAT-1] & out_stall);
	assign in_stall = ~en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[PIPE_LAT-2:0], in_valid};
		end
	end

	assign pt[0][0] = a_x;
	assign pt[0][1] = a_y;
	assign pt[0][2] = a_z;
	assign pt[1][0] = b_x;
	assign pt[1][1] = b_y;
	assign pt[1][2] = b_z;
	assign pt[2][0] = c_x;
	assign pt[2][1] = c_y;
	assign pt[2][2] = c_z;
	assign pt[3][0] = d_x;
	assign pt[3][1] = d_y;
	assign pt[3][2] = d_z;

	tcs_front u_front (
		.clk(clk),
		.en (en),
		.pt (pt),
		.p0 (p0),
		.sq (sq),
		.cr (cr),
		.det(det)
	);

	for (genvar j = 0; j < 3; j++) begin : g_lane
		logic signed [tcs_pkg::CR_W-1:0] cr_col [3];
		logic signed [tcs_pkg::DET_W-1:0] det_out;

		assign cr_col[0] = cr[0][j];
		assign cr_col[1] = cr[1][j];
		assign cr_col[2] = cr[2][j];

		tcs_lane u_lane (
			.clk    (clk),
			.en     (en),
			.p0     (p0[j]),
			.sq     (sq),
			.cr     (cr_col),
			.det    (det),
			.n_sum  (n_all[j]),
			.det_tap(det_out),
			.res    (lane_res[j])
		);

		if (j == 0) begin : g_tap
			assign det_tap = det_out;
		end

		// line the center up with the radius path
		always_ff @(posedge clk) begin
			if (en) begin
				cd_q[j][0] <= lane_res[j];
				for (int k = 1; k < CDELAY; k++) begin
					cd_q[j][k] <= cd_q[j][k-1];
				end
			end
		end
	end

	tcs_radius u_radius (
		.clk(clk),
		.en (en),
		.n  (n_all),
		.det(det_tap),
		.res(rad_res)
	);

	assign bad = rad_res.bad | cd_q[0][CDELAY-1].bad | cd_q[1][CDELAY-1].bad
		| cd_q[2][CDELAY-1].bad;

	always_ff @(posedge clk) begin
		if (en) begin
			cx_q    <= bad ? '0 : cd_q[0][CDELAY-1].center;
			cy_q    <= bad ? '0 : cd_q[1][CDELAY-1].center;
			cz_q    <= bad ? '0 : cd_q[2][CDELAY-1].center;
			rad_q   <= bad ? '0 : rad_res.radius;
			degen_q <= bad;
		end
	end

	assign out_valid     = vld_q[PIPE_LAT-1];
	assign center_x      = $signed(cx_q);
	assign center_y      = $signed(cy_q);
	assign center_z      = $signed(cz_q);
	assign sphere_radius = rad_q;
	assign degenerate    = degen_q;
endmodule

@@ rtl/tcs_div.sv @@
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per stage. Quotients that do not fit
// Q_W bits (and a zero divisor) raise ovf.
module tcs_div #(
	parameter int NUM_W = tcs_pkg::TOT_W,
	parameter int DEN_W = tcs_pkg::DET_W + 1,
	parameter int Q_W   = tcs_pkg::CQ_W
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo,
	output logic             ovf
);
	localparam int HI_W = NUM_W - Q_W;
	localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

	logic [DEN_W-1:0] rem_q [Q_W+1];
	logic [DEN_W-1:0] den_q [Q_W+1];
	logic [Q_W-1:0]   lo_q  [Q_W+1];
	logic [Q_W-1:0]   quo_q [Q_W+1];
	logic             ovf_q [Q_W+1];

	logic [CMP_W-1:0] hi_ext;
	logic [CMP_W-1:0] den_ext;
	logic             hi_ge;

	assign hi_ext  = CMP_W'(num[NUM_W-1:Q_W]);
	assign den_ext = CMP_W'(den);
	assign hi_ge   = hi_ext >= den_ext;

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= hi_ge ? '0 : DEN_W'(hi_ext);
			den_q[0] <= den;
			lo_q[0]  <= num[Q_W-1:0];
			quo_q[0] <= '0;
			ovf_q[0] <= hi_ge;
		end
	end

	for (genvar k = 1; k <= Q_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;

		assign trial = {rem_q[k-1], lo_q[k-1][Q_W-1]};
		// top bit of diff set means the trial came out below the divisor
		assign diff  = trial - {1'b0, den_q[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= diff[DEN_W] ? trial[DEN_W-1:0] : diff[DEN_W-1:0];
				den_q[k] <= den_q[k-1];
				lo_q[k]  <= lo_q[k-1] << 1;
				quo_q[k] <= {quo_q[k-1][Q_W-2:0], ~diff[DEN_W]};
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	assign quo = quo_q[Q_W];
	assign ovf = ovf_q[Q_W];
endmodule

@@ rtl/tcs_front.sv @@
`timescale 1ns / 1ps

// Edge vectors from the first corner, squared lengths, cofactors and the
// base determinant.
module tcs_front (
	input  logic                             clk,
	input  logic                             en,
	input  tcs_pkg::coord_t                  pt  [4][3],
	output tcs_pkg::coord_t                  p0  [3],
	output logic [tcs_pkg::SQ_W-1:0]         sq  [3],
	output logic signed [tcs_pkg::CR_W-1:0]  cr  [3][3],
	output logic signed [tcs_pkg::DET_W-1:0] det
);
	localparam int E_W = tcs_pkg::E_W;
	localparam int SQ_W = tcs_pkg::SQ_W;
	localparam int CR_W = tcs_pkg::CR_W;
	localparam int DET_W = tcs_pkg::DET_W;

	logic signed [E_W-1:0]   e_s1  [3][3];
	tcs_pkg::coord_t         p0_s1 [3];
	logic signed [E_W-1:0]   e_s2  [3];
	tcs_pkg::coord_t         p0_s2 [3];
	logic [SQ_W-1:0]         sq_s2 [3];
	logic signed [CR_W-1:0]  cr_s2 [3][3];
	tcs_pkg::coord_t         p0_s3 [3];
	logic [SQ_W-1:0]         sq_s3 [3];
	logic signed [CR_W-1:0]  cr_s3 [3][3];
	logic signed [DET_W-1:0] det_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					e_s1[i][j] <= E_W'(pt[i+1][j]) - E_W'(pt[0][j]);
				end
				p0_s1[i] <= pt[0][i];
			end
		end
	end

	for (genvar i = 0; i < 3; i++) begin : g_row
		localparam int RA = (i + 1) % 3;
		localparam int RB = (i + 2) % 3;
		logic signed [SQ_W-1:0] sq_sum;

		assign sq_sum = SQ_W'(e_s1[i][0]) * SQ_W'(e_s1[i][0])
			+ SQ_W'(e_s1[i][1]) * SQ_W'(e_s1[i][1])
			+ SQ_W'(e_s1[i][2]) * SQ_W'(e_s1[i][2]);

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s2[i]    <= $unsigned(sq_sum);
				cr_s2[i][0] <= CR_W'(e_s1[RA][1]) * CR_W'(e_s1[RB][2])
					- CR_W'(e_s1[RA][2]) * CR_W'(e_s1[RB][1]);
				cr_s2[i][1] <= CR_W'(e_s1[RA][2]) * CR_W'(e_s1[RB][0])
					- CR_W'(e_s1[RA][0]) * CR_W'(e_s1[RB][2]);
				cr_s2[i][2] <= CR_W'(e_s1[RA][0]) * CR_W'(e_s1[RB][1])
					- CR_W'(e_s1[RA][1]) * CR_W'(e_s1[RB][0]);
				e_s2[i]     <= e_s1[0][i];
				p0_s2[i]    <= p0_s1[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			det_s3 <= DET_W'(e_s2[0]) * DET_W'(cr_s2[0][0])
				+ DET_W'(e_s2[1]) * DET_W'(cr_s2[0][1])
				+ DET_W'(e_s2[2]) * DET_W'(cr_s2[0][2]);
			sq_s3  <= sq_s2;
			cr_s3  <= cr_s2;
			p0_s3  <= p0_s2;
		end
	end

	assign p0  = p0_s3;
	assign sq  = sq_s3;
	assign cr  = cr_s3;
	assign det = det_s3;
endmodule

@@ rtl/tcs_lane.sv @@
`timescale 1ns / 1ps

// One center coordinate: Cramer numerator, scaling, rounded division.
module tcs_lane (
	input  logic                             clk,
	input  logic                             en,
	input  tcs_pkg::coord_t                  p0,
	input  logic [tcs_pkg::SQ_W-1:0]         sq      [3],
	input  logic signed [tcs_pkg::CR_W-1:0]  cr      [3],
	input  logic signed [tcs_pkg::DET_W-1:0] det,
	output logic signed [tcs_pkg::N_W-1:0]   n_sum,
	output logic signed [tcs_pkg::DET_W-1:0] det_tap,
	output tcs_pkg::lane_res_t               res
);
	localparam int T_W = tcs_pkg::T_W;
	localparam int N_W = tcs_pkg::N_W;
	localparam int PD_W = tcs_pkg::PD_W;
	localparam int TOT_W = tcs_pkg::TOT_W;
	localparam int DET_W = tcs_pkg::DET_W;
	localparam int CQ_W = tcs_pkg::CQ_W;
	localparam int RES_W = tcs_pkg::RES_W;

	logic signed [T_W-1:0]   t_s1 [3];
	logic signed [PD_W-1:0]  pd_s1, pd_s2;
	logic signed [DET_W-1:0] det_s1, det_s2, det_s3;
	logic signed [N_W-1:0]   n_s2;
	logic signed [TOT_W-1:0] tot_s3;
	logic                    neg_s4, neg_s5;
	logic [TOT_W-1:0]        atot_s4;
	logic [DET_W-1:0]        adet_s4;
	logic [TOT_W-1:0]        num_s5;
	logic [DET_W:0]          den_s5;
	logic                    neg_q [CQ_W+1];
	logic [CQ_W-1:0]         quo;
	logic                    ovf;
	logic                    neg_d;
	logic                    lim_hit;
	tcs_pkg::lane_res_t      res_q;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				t_s1[i] <= T_W'($signed({1'b0, sq[i]})) * T_W'(cr[i]);
			end
			pd_s1  <= PD_W'(p0) * PD_W'(det);
			det_s1 <= det;

			n_s2   <= N_W'(t_s1[0]) + N_W'(t_s1[1]) + N_W'(t_s1[2]);
			pd_s2  <= pd_s1;
			det_s2 <= det_s1;

			// center * det in Q16.16 units, doubled later for rounding
			tot_s3 <= (TOT_W'(pd_s2) <<< tcs_pkg::COORD_FRAC)
				+ (TOT_W'(n_s2) <<< tcs_pkg::N_SCALE);
			det_s3 <= det_s2;

			neg_s4  <= tot_s3[TOT_W-1] ^ det_s3[DET_W-1];
			atot_s4 <= tot_s3[TOT_W-1] ? $unsigned(-tot_s3) : $unsigned(tot_s3);
			adet_s4 <= det_s3[DET_W-1] ? $unsigned(-det_s3) : $unsigned(det_s3);

			num_s5 <= {atot_s4[TOT_W-2:0], 1'b0} + TOT_W'(adet_s4);
			den_s5 <= {adet_s4, 1'b0};
			neg_s5 <= neg_s4;
		end
	end

	tcs_div #(
		.NUM_W(TOT_W),
		.DEN_W(DET_W + 1),
		.Q_W  (CQ_W)
	) u_div (
		.clk(clk),
		.en (en),
		.num(num_s5),
		.den(den_s5),
		.quo(quo),
		.ovf(ovf)
	);

	// carry the sign alongside the divider
	always_ff @(posedge clk) begin
		if (en) begin
			neg_q[0] <= neg_s5;
			for (int k = 1; k <= CQ_W; k++) begin
				neg_q[k] <= neg_q[k-1];
			end
		end
	end

	assign neg_d   = neg_q[CQ_W];
	assign lim_hit = neg_d ? (quo[RES_W-1] & (|quo[RES_W-2:0])) : quo[RES_W-1];

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.bad    <= ovf | lim_hit;
			res_q.center <= neg_d ? (~quo + RES_W'(1)) : quo;
		end
	end

	assign res     = res_q;
	assign n_sum   = n_s2;
	assign det_tap = det_s2;
endmodule

@@ rtl/tcs_radius.sv @@
`timescale 1ns / 1ps

// Radius: sum of squared numerators, square root, then divide by |det|.
// floor(isqrt(S * 2^16) / |det|) equals isqrt(S * 2^16 / det^2).
module tcs_radius (
	input  logic                             clk,
	input  logic                             en,
	input  logic signed [tcs_pkg::N_W-1:0]   n   [3],
	input  logic signed [tcs_pkg::DET_W-1:0] det,
	output tcs_pkg::rad_res_t                res
);
	localparam int N_W = tcs_pkg::N_W;
	localparam int NA_W = tcs_pkg::NA_W;
	localparam int HALF_W = tcs_pkg::HALF_W;
	localparam int SQR_W = tcs_pkg::SQR_W;
	localparam int DET_W = tcs_pkg::DET_W;
	localparam int ROOT_W = tcs_pkg::ROOT_W;
	localparam int X_W = tcs_pkg::X_W;
	localparam int RQ_W = tcs_pkg::RQ_W;
	localparam int RW = ROOT_W + 2;

	logic [NA_W-1:0]     an_s1 [3];
	logic [DET_W-1:0]    a_s1, a_s2, a_s3;
	logic [NA_W-1:0]     hh_s2 [3];
	logic [NA_W-1:0]     hl_s2 [3];
	logic [NA_W-1:0]     ll_s2 [3];
	logic [SQR_W-1:0]    sq_s3 [3];
	logic [SQR_W-1:0]    s_sum;
	logic [RW-1:0]       rem_q  [ROOT_W+1];
	logic [ROOT_W-1:0]   root_q [ROOT_W+1];
	logic [X_W-1:0]      x_q    [ROOT_W+1];
	logic [DET_W-1:0]    a_q    [ROOT_W+1];
	logic [RQ_W-1:0]     quo;
	logic                ovf;
	logic [RQ_W-1:0]     quo_inc;
	tcs_pkg::rad_res_t   res_q;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				an_s1[j] <= NA_W'(n[j][N_W-1] ? $unsigned(-n[j]) : $unsigned(n[j]));
			end
			a_s1 <= det[DET_W-1] ? $unsigned(-det) : $unsigned(det);

			// split each magnitude in halves to keep the multipliers narrow
			for (int j = 0; j < 3; j++) begin
				hh_s2[j] <= NA_W'(an_s1[j][NA_W-1:HALF_W]) * NA_W'(an_s1[j][NA_W-1:HALF_W]);
				hl_s2[j] <= NA_W'(an_s1[j][NA_W-1:HALF_W]) * NA_W'(an_s1[j][HALF_W-1:0]);
				ll_s2[j] <= NA_W'(an_s1[j][HALF_W-1:0]) * NA_W'(an_s1[j][HALF_W-1:0]);
			end
			a_s2 <= a_s1;

			for (int j = 0; j < 3; j++) begin
				sq_s3[j] <= (SQR_W'(hh_s2[j]) << NA_W)
					+ (SQR_W'(hl_s2[j]) << (HALF_W + 1))
					+ SQR_W'(ll_s2[j]);
			end
			a_s3 <= a_s2;

			x_q[0]    <= X_W'(s_sum) << tcs_pkg::X_SHIFT;
			rem_q[0]  <= '0;
			root_q[0] <= '0;
			a_q[0]    <= a_s3;
		end
	end

	assign s_sum = sq_s3[0] + sq_s3[1] + sq_s3[2];

	for (genvar k = 1; k <= ROOT_W; k++) begin : g_root
		logic [RW-1:0] pre;
		logic [RW-1:0] trial;
		logic [RW-1:0] diff;
		logic          ge;

		assign pre   = {rem_q[k-1][ROOT_W-1:0], x_q[k-1][X_W-1 -: 2]};
		assign trial = {root_q[k-1], 2'b01};
		assign diff  = pre - trial;
		assign ge    = pre >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k]  <= ge ? diff : pre;
				root_q[k] <= {root_q[k-1][ROOT_W-2:0], ge};
				x_q[k]    <= x_q[k-1] << 2;
				a_q[k]    <= a_q[k-1];
			end
		end
	end

	tcs_div #(
		.NUM_W(ROOT_W),
		.DEN_W(DET_W),
		.Q_W  (RQ_W)
	) u_div (
		.clk(clk),
		.en (en),
		.num(root_q[ROOT_W]),
		.den(a_q[ROOT_W]),
		.quo(quo),
		.ovf(ovf)
	);

	// result is the doubled radius; round half up while halving
	assign quo_inc = quo + RQ_W'(1);

	always_ff @(posedge clk) begin
		if (en) begin
			res_q.bad    <= ovf | (&quo);
			res_q.radius <= quo_inc[RQ_W-1:1];
		end
	end

	assign res = res_q;
endmodule

@@ rtl/tcs_checker.sv @@
`timescale 1ns / 1ps
`include "tetrahedron_circumsphere_unit_defines.svh"

module tcs_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               in_valid,
	input logic                               in_stall,
	input logic signed [tcs_pkg::COORD_W-1:0] a_x,
	input logic signed [tcs_pkg::COORD_W-1:0] a_y,
	input logic signed [tcs_pkg::COORD_W-1:0] a_z,
	input logic signed [tcs_pkg::COORD_W-1:0] b_x,
	input logic signed [tcs_pkg::COORD_W-1:0] b_y,
	input logic signed [tcs_pkg::COORD_W-1:0] b_z,
	input logic signed [tcs_pkg::COORD_W-1:0] c_x,
	input logic signed [tcs_pkg::COORD_W-1:0] c_y,
	input logic signed [tcs_pkg::COORD_W-1:0] c_z,
	input logic signed [tcs_pkg::COORD_W-1:0] d_x,
	input logic signed [tcs_pkg::COORD_W-1:0] d_y,
	input logic signed [tcs_pkg::COORD_W-1:0] d_z,
	input logic                               out_valid,
	input logic                               out_stall,
	input logic signed [tcs_pkg::RES_W-1:0]   center_x,
	input logic signed [tcs_pkg::RES_W-1:0]   center_y,
	input logic signed [tcs_pkg::RES_W-1:0]   center_z,
	input logic [tcs_pkg::RES_W-1:0]          sphere_radius,
	input logic                               degenerate
);
	// a degenerate result carries only zeros
	`TCS_ASSERT_NOW(a_degen_zero, clk, arst_n, out_valid && degenerate, center_x == 0 && center_y == 0 && center_z == 0 && sphere_radius == 0, "degenerate result with nonzero fields")

	// the input side stalls exactly while a result is held at the output
	`TCS_ASSERT_NOW(a_stall_link, clk, arst_n, 1'b1, in_stall == (out_valid && out_stall), "input stall does not follow held output")

	`TCS_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(center_x) && $stable(center_y) && $stable(center_z) && $stable(sphere_radius) && $stable(degenerate), "held result changed")
endmodule

bind tetrahedron_circumsphere_unit tcs_checker u_tcs_checker (.*);
